/* sv/clb_pkg.sv */
`default_nettype none
package clb_pkg;

    // Defaults of the top-level parameters.
    localparam int COORD_BITS_DEF = 16;
    localparam int PIXEL_BITS_DEF = 12;

    // Fixed widths of the configuration registers and request code.
    localparam int RAD_BITS   = 11;
    localparam int PAD_BITS   = 10;
    localparam int LH_BITS    = 10;
    localparam int FLY_BITS   = 16;
    localparam int TYPE_BITS  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Widths of the radius square and of the step counter of the serial units.
    localparam int SQ_W  = 2 * RAD_BITS;
    localparam int CNT_W = $clog2(RAD_BITS);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFE_RADIUS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_PAD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LINE_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT  = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [RAD_BITS-1:0] CENTER_Y_RST     = 11'd233;
    localparam logic [RAD_BITS-1:0] SAFE_RADIUS_RST  = 11'd233;
    localparam logic [PAD_BITS-1:0] EDGE_PAD_RST     = 10'd0;
    localparam logic [FLY_BITS-1:0] FIRST_LINE_Y_RST = 16'd0;
    localparam logic [LH_BITS-1:0]  LINE_HEIGHT_RST  = 10'd32;

    // Request codes.
    localparam logic [TYPE_BITS-1:0] REQ_BEGIN   = 2'd0;
    localparam logic [TYPE_BITS-1:0] REQ_UNIT    = 2'd1;
    localparam logic [TYPE_BITS-1:0] REQ_NEWLINE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHORD,
        ST_RETRY,
        ST_FINISH
    } clb_state_t;

    typedef enum logic [2:0] {
        CH_IDLE,
        CH_SQ,
        CH_LOAD,
        CH_ROOT,
        CH_OUT
    } clb_chord_state_t;

    // Circle geometry handed to the chord unit.
    typedef struct packed {
        logic [RAD_BITS-1:0] center_y;
        logic [RAD_BITS-1:0] radius;
        logic [PAD_BITS-1:0] pad;
    } clb_geom_t;

    // Sequencing of a serial unit.
    typedef struct packed {
        logic load;
        logic step;
    } clb_step_t;

endpackage
`default_nettype wire

/* sv/clb_req_if.sv */
`default_nettype none
interface clb_req_if #(
    parameter int PIXEL_BITS = clb_pkg::PIXEL_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [clb_pkg::TYPE_BITS-1:0]  req_type;
    logic [PIXEL_BITS-1:0]          unit_width;

    modport source (output valid, output req_type, output unit_width, input ready);
    modport sink   (input valid, input req_type, input unit_width, output ready);
endinterface
`default_nettype wire

/* sv/clb_rsp_if.sv */
`default_nettype none
interface clb_rsp_if #(
    parameter int COORD_BITS = clb_pkg::COORD_BITS_DEF,
    parameter int PIXEL_BITS = clb_pkg::PIXEL_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         break_before;
    logic                         break_after;
    logic signed [COORD_BITS-1:0] line_center;
    logic [PIXEL_BITS-1:0]        width_limit;

    modport source (output valid, output break_before, output break_after,
                    output line_center, output width_limit, input ready);
    modport sink   (input valid, input break_before, input break_after,
                    input line_center, input width_limit, output ready);
endinterface
`default_nettype wire

/* sv/clb_sqdiff.sv */
`default_nettype none
// Serial shift-and-add unit that forms r*r - m*m, one bit of each
// multiplier per step.
module clb_sqdiff (
    input  wire logic                         clk,
    input  wire clb_pkg::clb_step_t           ctl,
    input  wire logic [clb_pkg::RAD_BITS-1:0] r,
    input  wire logic [clb_pkg::RAD_BITS-1:0] m,
    output logic      [clb_pkg::SQ_W-1:0]     diff
);
    logic [clb_pkg::RAD_BITS-1:0] r_bits_reg, r_bits_next;
    logic [clb_pkg::RAD_BITS-1:0] m_bits_reg, m_bits_next;
    logic [clb_pkg::SQ_W-1:0]     r_sh_reg, r_sh_next;
    logic [clb_pkg::SQ_W-1:0]     m_sh_reg, m_sh_next;
    logic signed [clb_pkg::SQ_W:0] acc_reg, acc_next;
    logic signed [clb_pkg::SQ_W:0] add_t, sub_t;

    always_comb
    begin
        add_t       = r_bits_reg[0] ? $signed({1'b0, r_sh_reg}) : '0;
        sub_t       = m_bits_reg[0] ? $signed({1'b0, m_sh_reg}) : '0;
        r_bits_next = r_bits_reg;
        m_bits_next = m_bits_reg;
        r_sh_next   = r_sh_reg;
        m_sh_next   = m_sh_reg;
        acc_next    = acc_reg;
        if (ctl.load)
        begin
            r_bits_next = r;
            m_bits_next = m;
            r_sh_next   = clb_pkg::SQ_W'(r);
            m_sh_next   = clb_pkg::SQ_W'(m);
            acc_next    = '0;
        end
        else if (ctl.step)
        begin
            acc_next    = acc_reg + add_t - sub_t;
            r_bits_next = r_bits_reg >> 1;
            m_bits_next = m_bits_reg >> 1;
            r_sh_next   = r_sh_reg << 1;
            m_sh_next   = m_sh_reg << 1;
        end
    end

    always_ff @(posedge clk)
    begin
        r_bits_reg <= r_bits_next;
        m_bits_reg <= m_bits_next;
        r_sh_reg   <= r_sh_next;
        m_sh_reg   <= m_sh_next;
        acc_reg    <= acc_next;
    end

    // The caller keeps m below r, so the finished sum is never negative.
    assign diff = acc_reg[clb_pkg::SQ_W-1:0];
endmodule
`default_nettype wire

/* sv/clb_isqrt.sv */
`default_nettype none
// Restoring integer square root, two radicand bits and one root bit per step.
module clb_isqrt (
    input  wire logic                         clk,
    input  wire clb_pkg::clb_step_t           ctl,
    input  wire logic [clb_pkg::SQ_W-1:0]     value,
    output logic      [clb_pkg::RAD_BITS-1:0] root
);
    localparam int REM_W = clb_pkg::RAD_BITS + 1;
    localparam int SH_W  = clb_pkg::RAD_BITS + 3;

    logic [clb_pkg::SQ_W-1:0]     val_reg, val_next;
    logic [REM_W-1:0]             rem_reg, rem_next;
    logic [clb_pkg::RAD_BITS-1:0] root_reg, root_next;
    logic [SH_W-1:0]              rem_sh, trial, rem_sub;

    always_comb
    begin
        rem_sh    = {rem_reg, val_reg[clb_pkg::SQ_W-1 -: 2]};
        trial     = SH_W'({root_reg, 2'b01});
        rem_sub   = rem_sh - trial;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (ctl.load)
        begin
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
        end
        else if (ctl.step)
        begin
            val_next = val_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sub[REM_W-1:0];
                root_next = {root_reg[clb_pkg::RAD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {root_reg[clb_pkg::RAD_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
endmodule
`default_nettype wire

/* sv/clb_chord.sv */
`default_nettype none
// Chord width of the text circle at a given line centre. A start launches
// the serial square difference and then the serial square root, or neither for
// a line outside the circle; done pulses for one cycle, width held to next done.
module clb_chord #(
    parameter int COORD_BITS = clb_pkg::COORD_BITS_DEF,
    parameter int PIXEL_BITS = clb_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic signed [COORD_BITS-1:0] y,
    input  wire clb_pkg::clb_geom_t           geom,
    output logic                              done,
    output logic [PIXEL_BITS-1:0]             width
);
    localparam int RB = clb_pkg::RAD_BITS;
    localparam logic [clb_pkg::CNT_W-1:0] LAST = clb_pkg::CNT_W'(RB - 1);
    localparam logic [31:0] PIX_MAX = 32'((64'd1 << PIXEL_BITS) - 64'd1);

    clb_pkg::clb_chord_state_t state_reg, state_next;
    logic [clb_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      oor_reg, oor_next;
    logic                      done_reg, done_next;
    logic [PIXEL_BITS-1:0]     width_reg, width_next;

    clb_pkg::clb_step_t        sq_ctl, rt_ctl;
    logic [clb_pkg::SQ_W-1:0]  sq_diff;
    logic [RB-1:0]             root;

    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS:0]        mag;
    logic                       oor;
    logic signed [RB:0]         half_w;
    logic [RB:0]                w_full;
    logic [31:0]                w_ext;

    // Distance from the circle centre; at or beyond the radius the chord is empty.
    always_comb
    begin
        dy  = (COORD_BITS + 1)'(y) - $signed((COORD_BITS + 1)'(geom.center_y));
        mag = dy[COORD_BITS] ? $unsigned(-dy) : $unsigned(dy);
        oor = mag >= (COORD_BITS + 1)'(geom.radius);
    end

    // Width = 2*(root - pad), clamped below at zero and above at the field range.
    always_comb
    begin
        half_w = $signed({1'b0, root}) - $signed((RB + 1)'(geom.pad));
        if (oor_reg || half_w[RB])
            w_full = '0;
        else
            w_full = {half_w[RB-1:0], 1'b0};
        w_ext = 32'(w_full);
    end

    clb_sqdiff u_sqdiff (
        .clk  (clk),
        .ctl  (sq_ctl),
        .r    (geom.radius),
        .m    (mag[RB-1:0]),
        .diff (sq_diff)
    );

    clb_isqrt u_isqrt (
        .clk   (clk),
        .ctl   (rt_ctl),
        .value (sq_diff),
        .root  (root)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        oor_next   = oor_reg;
        done_next  = 1'b0;
        width_next = width_reg;
        sq_ctl     = '0;
        rt_ctl     = '0;
        case (state_reg)
            clb_pkg::CH_IDLE:
            begin
                if (start)
                begin
                    sq_ctl.load = 1'b1;
                    oor_next    = oor;
                    cnt_next    = '0;
                    state_next  = oor ? clb_pkg::CH_OUT : clb_pkg::CH_SQ;
                end
            end
            clb_pkg::CH_SQ:
            begin
                sq_ctl.step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = clb_pkg::CH_LOAD;
                end
            end
            clb_pkg::CH_LOAD:
            begin
                rt_ctl.load = 1'b1;
                state_next  = clb_pkg::CH_ROOT;
            end
            clb_pkg::CH_ROOT:
            begin
                rt_ctl.step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = clb_pkg::CH_OUT;
                end
            end
            clb_pkg::CH_OUT:
            begin
                done_next  = 1'b1;
                width_next = (w_ext > PIX_MAX) ? '1 : PIXEL_BITS'(w_ext);
                state_next = clb_pkg::CH_IDLE;
            end
            default:
            begin
                state_next = clb_pkg::CH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clb_pkg::CH_IDLE;
            cnt_reg   <= '0;
            oor_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            oor_reg   <= oor_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
    end

    assign done  = done_reg;
    assign width = width_reg;
endmodule
`default_nettype wire

/* sv/circle_chord_line_breaker_core.sv */
// Greedy line breaker for text drawn on a round display.
// Items arrive on the req channel (valid/ready): a begin-text marker, a
// measured text unit with its pixel width, or a hard newline. Each item gives
// exactly one item on the rsp channel: break flags, the centre y of the line
// that is current afterwards and that line's chord width limit.
// Configuration is written through cfg_we/cfg_idx/cfg_data; the user writes
// it only while idle, as the block itself does not enforce this. A unit that
// fits on the line passes through the finish state to the output register.
// Every line advance (begin, newline, break) runs the chord unit: the serial
// squarer (11 steps) and the serial square root (11 steps), or neither when
// the line lies outside the circle. A unit that breaks before itself is tried
// again on the new line in the retry state and may cause a second advance.
// One item is worked on at a time; ready returns with the registered result,
// so the next item can enter while the previous result waits to be taken.
// Reset clears the line state (y 0, nothing used, limit 0) and returns the
// registers to their defaults. When the receiver stalls, the result is held
// in the output register and a finished item waits until it is taken.
`default_nettype none
module circle_chord_line_breaker_core #(
    parameter int COORD_BITS = clb_pkg::COORD_BITS_DEF,
    parameter int PIXEL_BITS = clb_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    clb_req_if.sink                                req,
    clb_rsp_if.source                              rsp,
    input  wire logic                              cfg_we,
    input  wire logic [clb_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire logic [clb_pkg::CFG_DATA_W-1:0]    cfg_data
);
    localparam logic signed [32:0] CMAX = (33'sd1 <<< (COORD_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] CMIN = -CMAX - 33'sd1;

    // Configuration registers.
    logic [clb_pkg::RAD_BITS-1:0] center_y_reg;
    logic [clb_pkg::RAD_BITS-1:0] safe_radius_reg;
    logic [clb_pkg::PAD_BITS-1:0] edge_pad_reg;
    logic [clb_pkg::FLY_BITS-1:0] first_line_y_reg;
    logic [clb_pkg::LH_BITS-1:0]  line_height_reg;

    // Line state and the item in flight.
    clb_pkg::clb_state_t          state_reg, state_next;
    logic signed [COORD_BITS-1:0] line_y_reg, line_y_next;
    logic [PIXEL_BITS-1:0]        used_reg, used_next;
    logic [PIXEL_BITS-1:0]        max_reg, max_next;
    logic [PIXEL_BITS-1:0]        unit_w_reg, unit_w_next;
    logic                         retry_reg, retry_next;
    logic                         bb_reg, bb_next;
    logic                         ba_reg, ba_next;
    logic                         start_reg, start_next;

    // Output register.
    logic                         rsp_valid_reg, rsp_valid_next;
    logic                         rsp_bb_reg, rsp_ba_reg;
    logic signed [COORD_BITS-1:0] rsp_y_reg;
    logic [PIXEL_BITS-1:0]        rsp_w_reg;
    logic                         rsp_load;

    clb_pkg::clb_geom_t           geom;
    logic                         chord_done;
    logic [PIXEL_BITS-1:0]        chord_width;

    logic signed [32:0]           fly_ext;
    logic signed [COORD_BITS-1:0] fly_y;
    logic signed [COORD_BITS:0]   adv_sum;
    logic signed [COORD_BITS-1:0] adv_y;
    logic [PIXEL_BITS:0]          used_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_y_reg     <= clb_pkg::CENTER_Y_RST;
            safe_radius_reg  <= clb_pkg::SAFE_RADIUS_RST;
            edge_pad_reg     <= clb_pkg::EDGE_PAD_RST;
            first_line_y_reg <= clb_pkg::FIRST_LINE_Y_RST;
            line_height_reg  <= clb_pkg::LINE_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                clb_pkg::CFG_CENTER_Y:
                    center_y_reg <= cfg_data[clb_pkg::RAD_BITS-1:0];
                clb_pkg::CFG_SAFE_RADIUS:
                    safe_radius_reg <= cfg_data[clb_pkg::RAD_BITS-1:0];
                clb_pkg::CFG_EDGE_PAD:
                    edge_pad_reg <= cfg_data[clb_pkg::PAD_BITS-1:0];
                clb_pkg::CFG_FIRST_LINE_Y:
                    first_line_y_reg <= cfg_data[clb_pkg::FLY_BITS-1:0];
                clb_pkg::CFG_LINE_HEIGHT:
                    line_height_reg <= cfg_data[clb_pkg::LH_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The first line's y is clamped into the coordinate range, and a line
    // advance saturates at the largest coordinate.
    always_comb
    begin
        fly_ext = 33'($signed(first_line_y_reg));
        if (fly_ext > CMAX)
            fly_y = COORD_BITS'(CMAX);
        else if (fly_ext < CMIN)
            fly_y = COORD_BITS'(CMIN);
        else
            fly_y = COORD_BITS'(fly_ext);

        adv_sum = (COORD_BITS + 1)'(line_y_reg)
                + $signed((COORD_BITS + 1)'(line_height_reg));
        if (adv_sum[COORD_BITS] != adv_sum[COORD_BITS-1])
            adv_y = COORD_BITS'(CMAX);
        else
            adv_y = adv_sum[COORD_BITS-1:0];

        used_sum = {1'b0, used_reg} + {1'b0, req.unit_width};
    end

    assign geom.center_y = center_y_reg;
    assign geom.radius   = safe_radius_reg;
    assign geom.pad      = edge_pad_reg;

    clb_chord #(
        .COORD_BITS (COORD_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_chord (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .y     (line_y_reg),
        .geom  (geom),
        .done  (chord_done),
        .width (chord_width)
    );

    always_comb
    begin
        state_next  = state_reg;
        line_y_next = line_y_reg;
        used_next   = used_reg;
        max_next    = max_reg;
        unit_w_next = unit_w_reg;
        retry_next  = retry_reg;
        bb_next     = bb_reg;
        ba_next     = ba_reg;
        start_next  = 1'b0;
        rsp_load    = 1'b0;
        case (state_reg)
            clb_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    unit_w_next = req.unit_width;
                    bb_next     = 1'b0;
                    ba_next     = 1'b0;
                    retry_next  = 1'b0;
                    case (req.req_type)
                        clb_pkg::REQ_BEGIN:
                        begin
                            line_y_next = fly_y;
                            used_next   = '0;
                            start_next  = 1'b1;
                            state_next  = clb_pkg::ST_CHORD;
                        end
                        clb_pkg::REQ_UNIT:
                        begin
                            if (used_reg != '0 && used_sum > {1'b0, max_reg})
                            begin
                                // Overflow: close the line and try the unit
                                // again on the next one.
                                bb_next     = 1'b1;
                                retry_next  = 1'b1;
                                line_y_next = adv_y;
                                used_next   = '0;
                                start_next  = 1'b1;
                                state_next  = clb_pkg::ST_CHORD;
                            end
                            else if (used_reg == '0 && req.unit_width > max_reg)
                            begin
                                // Too wide even for an empty line: it sits
                                // alone and the line ends after it.
                                ba_next     = 1'b1;
                                line_y_next = adv_y;
                                used_next   = '0;
                                start_next  = 1'b1;
                                state_next  = clb_pkg::ST_CHORD;
                            end
                            else
                            begin
                                used_next  = used_sum[PIXEL_BITS-1:0];
                                state_next = clb_pkg::ST_FINISH;
                            end
                        end
                        clb_pkg::REQ_NEWLINE:
                        begin
                            ba_next     = 1'b1;
                            line_y_next = adv_y;
                            used_next   = '0;
                            start_next  = 1'b1;
                            state_next  = clb_pkg::ST_CHORD;
                        end
                        default:
                        begin
                            state_next = clb_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            clb_pkg::ST_CHORD:
            begin
                if (chord_done)
                begin
                    max_next   = chord_width;
                    state_next = retry_reg ? clb_pkg::ST_RETRY : clb_pkg::ST_FINISH;
                end
            end
            clb_pkg::ST_RETRY:
            begin
                // The line is empty here, so only the oversized test remains.
                retry_next = 1'b0;
                if (unit_w_reg > max_reg)
                begin
                    ba_next     = 1'b1;
                    line_y_next = adv_y;
                    start_next  = 1'b1;
                    state_next  = clb_pkg::ST_CHORD;
                end
                else
                begin
                    used_next  = unit_w_reg;
                    state_next = clb_pkg::ST_FINISH;
                end
            end
            clb_pkg::ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = clb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = clb_pkg::ST_IDLE;
            end
        endcase

        rsp_valid_next = rsp_load | (rsp_valid_reg & ~rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= clb_pkg::ST_IDLE;
            line_y_reg    <= '0;
            used_reg      <= '0;
            max_reg       <= '0;
            retry_reg     <= 1'b0;
            start_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            line_y_reg    <= line_y_next;
            used_reg      <= used_next;
            max_reg       <= max_next;
            retry_reg     <= retry_next;
            start_reg     <= start_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_w_reg <= unit_w_next;
        bb_reg     <= bb_next;
        ba_reg     <= ba_next;
        if (rsp_load)
        begin
            rsp_bb_reg <= bb_reg;
            rsp_ba_reg <= ba_reg;
            rsp_y_reg  <= line_y_reg;
            rsp_w_reg  <= max_reg;
        end
    end

    assign req.ready        = (state_reg == clb_pkg::ST_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.break_before = rsp_bb_reg;
    assign rsp.break_after  = rsp_ba_reg;
    assign rsp.line_center  = rsp_y_reg;
    assign rsp.width_limit  = rsp_w_reg;
endmodule
`default_nettype wire

/* sv/clb_checker.sv */
`default_nettype none
module clb_checker #(
    parameter int COORD_BITS = clb_pkg::COORD_BITS_DEF,
    parameter int PIXEL_BITS = clb_pkg::PIXEL_BITS_DEF
) (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_ready,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_ready,
    input wire logic                         break_before,
    input wire logic                         break_after,
    input wire logic signed [COORD_BITS-1:0] line_center,
    input wire logic [PIXEL_BITS-1:0]        width_limit
);
    // A stalled result stays put.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(break_before)
            && $stable(break_after) && $stable(line_center) && $stable(width_limit))
        else $error("stalled result changed or dropped");

    // Only one item is worked on at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item accepted while one is in flight");

    // A new result appears together with the return to idle.
    a_rsp_with_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> req_ready)
        else $error("result raised while an item is still in flight");

    // No result can be ready in the cycle straight after an item is taken.
    a_no_instant_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("result appeared without any work cycle");
endmodule

bind circle_chord_line_breaker_core clb_checker #(
    .COORD_BITS (COORD_BITS),
    .PIXEL_BITS (PIXEL_BITS)
) u_clb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .break_before (rsp.break_before),
    .break_after  (rsp.break_after),
    .line_center  (rsp.line_center),
    .width_limit  (rsp.width_limit)
);
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    // The fourth request code has no meaning in the block.
    // It must be ignored: no break, no change of state.
    localparam logic [clb_pkg::TYPE_BITS-1:0] REQ_UNUSED = 2'd3;

    localparam int PX_MAX      = (1 << clb_pkg::PIXEL_BITS_DEF) - 1;
    localparam int Y_MAX       = (1 << (clb_pkg::COORD_BITS_DEF - 1)) - 1;
    localparam int CYCLE_LIMIT = 400000;

    // One result item as the block should present it.
    typedef struct packed {
        logic                                      brk_before;
        logic                                      brk_after;
        logic signed [clb_pkg::COORD_BITS_DEF-1:0] centre;
        logic [clb_pkg::PIXEL_BITS_DEF-1:0]        limit;
    } line_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [clb_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [clb_pkg::CFG_DATA_W-1:0] cfg_data;

    clb_req_if req_if ();
    clb_rsp_if rsp_if ();

    circle_chord_line_breaker_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_if),
        .rsp      (rsp_if),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // Results still owed by the block, oldest first.
    line_result_t pending_lines[$];

    // Our own copy of the register file, as last written.
    int geo_centre;
    int geo_radius;
    int geo_pad;
    int geo_first_y;
    int geo_line_step;

    // Our own copy of the line state.
    int cur_line_y;
    int cur_used_px;
    int cur_limit_px;

    // When set, neither side idles; used for the long quiet stretch.
    bit steady;
    // Cycles for which the receiver refuses every result item.
    int rx_hold;

    int fail_count;
    int checked_count;
    int setting_count;
    int before_count;
    int after_count;
    int saturated_count;
    int cycle_count;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Line-breaking predictor
    // ------------------------------------------------------------------

    // Floor square root, found one bit at a time from the top. Radii are at
    // most 11 bits wide, so the root never needs more than 11 bits.
    function automatic int floor_root(int v);
        int root;
        int trial;
        root = 0;
        for (int b = clb_pkg::RAD_BITS - 1; b >= 0; b--)
        begin
            trial = root + (1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Usable width of the horizontal chord of the text circle at height y,
    // less the pad at both ends. Lines outside the circle get no room.
    function automatic int chord_px(int y);
        int dy;
        int w;
        dy = y - geo_centre;
        if (dy < 0)
            dy = -dy;
        if (dy >= geo_radius)
            return 0;
        w = 2 * floor_root(geo_radius * geo_radius - dy * dy) - 2 * geo_pad;
        if (w < 0)
            w = 0;
        if (w > PX_MAX)
            w = PX_MAX;
        return w;
    endfunction

    // Moves to the next line; y sticks at the top of the signed range.
    function automatic void next_line();
        cur_line_y = cur_line_y + geo_line_step;
        if (cur_line_y > Y_MAX)
            cur_line_y = Y_MAX;
        cur_used_px = 0;
        cur_limit_px = chord_px(cur_line_y);
    endfunction

    function automatic line_result_t place_item(
        logic [clb_pkg::TYPE_BITS-1:0] kind,
        logic [clb_pkg::PIXEL_BITS_DEF-1:0] width);
        line_result_t r;
        int w;
        w = int'(width);
        r = '0;
        case (kind)
            clb_pkg::REQ_BEGIN:
            begin
                cur_line_y = geo_first_y;
                cur_used_px = 0;
                cur_limit_px = chord_px(cur_line_y);
            end
            clb_pkg::REQ_UNIT:
            begin
                // A unit that would overflow a partly filled line starts a new one.
                if (cur_used_px > 0 && cur_used_px + w > cur_limit_px)
                begin
                    r.brk_before = 1'b1;
                    next_line();
                end
                // A unit too wide even for an empty line takes that line alone.
                if (cur_used_px == 0 && w > cur_limit_px)
                begin
                    r.brk_after = 1'b1;
                    next_line();
                end
                else
                    cur_used_px = cur_used_px + w;
            end
            clb_pkg::REQ_NEWLINE:
            begin
                r.brk_after = 1'b1;
                next_line();
            end
            default:
            begin
            end
        endcase
        r.centre = cur_line_y[clb_pkg::COORD_BITS_DEF-1:0];
        r.limit  = cur_limit_px[clb_pkg::PIXEL_BITS_DEF-1:0];
        return r;
    endfunction

    // Each accepted request item is turned into the result it should cause.
    always @(posedge clk)
    begin
        if (rst_n && req_if.valid && req_if.ready)
            pending_lines.insert(pending_lines.size(),
                                 place_item(req_if.req_type, req_if.unit_width));
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    // Every result item taken is matched against the oldest expectation.
    always @(posedge clk)
    begin
        line_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_lines.size() == 0)
            begin
                $error("result item with nothing outstanding: before %0d after %0d y %0d limit %0d",
                       rsp_if.break_before, rsp_if.break_after, rsp_if.line_center,
                       rsp_if.width_limit);
                fail_count++;
            end
            else
            begin
                want = pending_lines.pop_front();
                checked_count++;
                if (rsp_if.break_before !== want.brk_before)
                begin
                    $error("break_before: expected %0d, got %0d", want.brk_before,
                           rsp_if.break_before);
                    fail_count++;
                end
                if (rsp_if.break_after !== want.brk_after)
                begin
                    $error("break_after: expected %0d, got %0d", want.brk_after,
                           rsp_if.break_after);
                    fail_count++;
                end
                if (rsp_if.line_center !== want.centre)
                begin
                    $error("line_center: expected %0d, got %0d", want.centre,
                           rsp_if.line_center);
                    fail_count++;
                end
                if (rsp_if.width_limit !== want.limit)
                begin
                    $error("width_limit: expected %0d, got %0d", want.limit,
                           rsp_if.width_limit);
                    fail_count++;
                end
                if (want.brk_before)
                    before_count++;
                if (want.brk_after)
                    after_count++;
                if (want.centre == Y_MAX)
                    saturated_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: idles about 29 percent of the time, unless the quiet
    // stretch is on, and refuses everything while a hold-off is counted.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rsp_if.ready <= 1'b0;
            rx_hold--;
        end
        else
            rsp_if.ready <= steady || ($urandom_range(99) >= 29);
    end

    // ------------------------------------------------------------------
    // Sender and configuration helpers
    // ------------------------------------------------------------------

    // Offers one request item and returns at the edge that accepts it. The
    // sender may idle first; valid stays high from one item to the next
    // unless it idles, so nothing is lowered and raised in the same step.
    task automatic send_item(input logic [clb_pkg::TYPE_BITS-1:0] kind,
                             input logic [clb_pkg::PIXEL_BITS_DEF-1:0] width);
        @(negedge clk);
        if (!steady && $urandom_range(99) < 29)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= kind;
        req_if.unit_width <= width;
        do @(posedge clk); while (!req_if.ready);
    endtask

    // Withdraws valid once the last item of a burst has gone.
    task automatic req_release();
        @(negedge clk);
        req_if.valid <= 1'b0;
    endtask

    // Every item gives a result, so the block is idle once all have come.
    task automatic wait_drained();
        while (pending_lines.size() != 0)
            @(posedge clk);
    endtask

    // Writes all five registers in a row and updates our copy of them.
    task automatic configure(input int centre, input int radius, input int pad,
                             input int first_y, input int step);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= clb_pkg::CFG_CENTER_Y;
        cfg_data <= 16'(centre);
        @(negedge clk);
        cfg_idx  <= clb_pkg::CFG_SAFE_RADIUS;
        cfg_data <= 16'(radius);
        @(negedge clk);
        cfg_idx  <= clb_pkg::CFG_EDGE_PAD;
        cfg_data <= 16'(pad);
        @(negedge clk);
        cfg_idx  <= clb_pkg::CFG_FIRST_LINE_Y;
        cfg_data <= 16'(first_y);
        @(negedge clk);
        cfg_idx  <= clb_pkg::CFG_LINE_HEIGHT;
        cfg_data <= 16'(step);
        @(negedge clk);
        cfg_we <= 1'b0;
        geo_centre    = centre & 32'h7FF;
        geo_radius    = radius & 32'h7FF;
        geo_pad       = pad & 32'h3FF;
        geo_first_y   = int'($signed(16'(first_y)));
        geo_line_step = step & 32'h3FF;
        setting_count++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Units before any begin-text marker work on the reset state: y 0 and
    // no room, so any unit of non-zero width is oversized. The registers
    // still hold their reset values here.
    task automatic test_units_before_begin();
        send_item(clb_pkg::REQ_UNIT, 12'd0);
        send_item(clb_pkg::REQ_UNIT, 12'd4095);
        send_item(clb_pkg::REQ_UNIT, 12'd1);
        send_item(clb_pkg::REQ_NEWLINE, 12'd0);
        send_item(REQ_UNUSED, 12'hFFF);
        req_release();
        wait_drained();
    endtask

    // A plain text layout through the middle of the circle: fitting units,
    // a unit that overflows a line, one too wide for any line, one that
    // breaks on both sides, a zero-width unit, a hard newline and the
    // unused request code.
    task automatic test_plain_layout();
        configure(233, 233, 8, 100, 32);
        send_item(clb_pkg::REQ_BEGIN, 12'd0);
        send_item(clb_pkg::REQ_UNIT, 12'd300);
        send_item(clb_pkg::REQ_UNIT, 12'd100);
        send_item(clb_pkg::REQ_UNIT, 12'd0);
        send_item(clb_pkg::REQ_UNIT, 12'd4095);
        send_item(clb_pkg::REQ_UNIT, 12'd200);
        send_item(clb_pkg::REQ_UNIT, 12'd4000);
        send_item(clb_pkg::REQ_NEWLINE, 12'd4095);
        send_item(REQ_UNUSED, 12'd0);
        send_item(clb_pkg::REQ_BEGIN, 12'hABC);
        req_release();
        wait_drained();
    endtask

    // Register extremes: the widest chord with no line step, a zero radius
    // with the line pushed into saturation, and the lowest first line.
    task automatic test_register_extremes();
        configure(2047, 2047, 0, 2047, 0);
        send_item(clb_pkg::REQ_BEGIN, 12'd0);
        send_item(clb_pkg::REQ_UNIT, 12'd4094);
        send_item(clb_pkg::REQ_UNIT, 12'd1);
        send_item(clb_pkg::REQ_UNIT, 12'd4095);
        req_release();
        wait_drained();

        configure(0, 0, 1023, 32767, 1023);
        send_item(clb_pkg::REQ_BEGIN, 12'd0);
        send_item(clb_pkg::REQ_UNIT, 12'd5);
        send_item(clb_pkg::REQ_NEWLINE, 12'd0);
        req_release();
        wait_drained();

        configure(0, 2047, 1023, -32768, 1023);
        send_item(clb_pkg::REQ_BEGIN, 12'd0);
        send_item(clb_pkg::REQ_NEWLINE, 12'd0);
        req_release();
        wait_drained();
    endtask

    // Random text blocks, each under a random geometry. Most items are units
    // sized to the circle, so lines fill and break as real text would; a few
    // are newlines, fresh begins, full-range widths and the unused code.
    // One block runs with no idling on either side.
    task automatic test_random_text(input int blocks, input int block_items);
        int p;
        int i;
        int centre;
        int radius;
        int pad;
        int first_y;
        int step;
        int span;
        int pick;
        logic [clb_pkg::PIXEL_BITS_DEF-1:0] w;
        for (p = 0; p < blocks; p++)
        begin
            centre = $urandom_range(0, 2047);
            radius = ($urandom_range(9) == 0) ? 0 : $urandom_range(16, 2047);
            pad = ($urandom_range(4) == 0) ? $urandom_range(0, 1023)
                                           : $urandom_range(0, radius / 8);
            first_y = centre - radius + int'($urandom_range(0, radius / 4));
            if ($urandom_range(7) == 0)
                first_y = Y_MAX - int'($urandom_range(0, 3000));
            step = ($urandom_range(9) == 0) ? $urandom_range(0, 1023)
                                            : $urandom_range(1, radius / 6 + 1);
            span = radius / 3 + 1;
            steady = (p == 3);
            configure(centre, radius, pad, first_y, step);
            send_item(clb_pkg::REQ_BEGIN, 12'($urandom));
            for (i = 0; i < block_items; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 3)
                    send_item(clb_pkg::REQ_BEGIN, 12'($urandom));
                else if (pick < 5)
                    send_item(REQ_UNUSED, 12'($urandom));
                else if (pick < 15)
                    send_item(clb_pkg::REQ_NEWLINE, 12'($urandom));
                else
                begin
                    pick = $urandom_range(9);
                    if (pick == 0)
                        w = '0;
                    else if (pick == 1)
                        w = 12'($urandom_range(0, PX_MAX));
                    else
                        w = 12'($urandom_range(1, span));
                    send_item(clb_pkg::REQ_UNIT, w);
                end
            end
            req_release();
            wait_drained();
        end
        steady = 1'b0;
    endtask

    // The receiver refuses results for a long stretch while the sender keeps
    // offering units back to back, so the block fills and stalls its input.
    task automatic test_output_stall();
        int i;
        steady = 1'b1;
        configure(400, 380, 4, 40, 24);
        send_item(clb_pkg::REQ_BEGIN, 12'd0);
        rx_hold = 300;
        for (i = 0; i < 30; i++)
            send_item(($urandom_range(5) == 0) ? clb_pkg::REQ_NEWLINE : clb_pkg::REQ_UNIT,
                      12'($urandom_range(1, 200)));
        req_release();
        wait_drained();
        steady = 1'b0;
    endtask

    // Timeout guard.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, pending_lines.size());
        $display("** circle_chord_line_breaker_core: FAILED **");
        $finish;
    end

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = '0;
        cfg_data          = '0;
        req_if.valid      = 1'b0;
        req_if.req_type   = clb_pkg::REQ_BEGIN;
        req_if.unit_width = '0;
        rsp_if.ready      = 1'b0;
        steady            = 1'b0;
        rx_hold           = 0;
        fail_count        = 0;
        checked_count     = 0;
        setting_count     = 0;
        before_count      = 0;
        after_count       = 0;
        saturated_count   = 0;

        // Register defaults and the cleared line state after reset.
        geo_centre    = int'(clb_pkg::CENTER_Y_RST);
        geo_radius    = int'(clb_pkg::SAFE_RADIUS_RST);
        geo_pad       = int'(clb_pkg::EDGE_PAD_RST);
        geo_first_y   = int'($signed(clb_pkg::FIRST_LINE_Y_RST));
        geo_line_step = int'(clb_pkg::LINE_HEIGHT_RST);
        cur_line_y    = 0;
        cur_used_px   = 0;
        cur_limit_px  = 0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_units_before_begin();
        test_plain_layout();
        test_register_extremes();
        test_random_text(13, 130);
        test_output_stall();

        // Allow for two line advances before declaring the block quiet, so
        // that any stray result item is still caught.
        wait_drained();
        repeat (60) @(posedge clk);

        $display("Checked %0d result items under %0d register settings.",
                 checked_count, setting_count);
        $display("Breaks before a unit: %0d, after: %0d, on a saturated line: %0d.",
                 before_count, after_count, saturated_count);
        if (fail_count == 0)
            $display("** circle_chord_line_breaker_core: PASSED **");
        else
            $display("** circle_chord_line_breaker_core: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
